[hw/rtl/double_ended_queue_assert.svh]
// assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// condition must hold in the cycle after the trigger
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

[hw/rtl/ddq_pkg.sv]
// types and constants shared by the double-ended queue files
`timescale 1ns / 1ps

package ddq_pkg;

    localparam int VALUE_W = 8;
    localparam int OCC_W   = 5;

    // requested operation
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    // what one cell row does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_SHIFT_IN  = 2'd1,
        CELL_SHIFT_OUT = 2'd2,
        CELL_LOAD      = 2'd3
    } cell_op_t;

    // control broadcast to every cell
    typedef struct packed {
        cell_op_t             front_op;
        cell_op_t             rear_op;
        logic [VALUE_W-1:0]   value;
    } cell_ctrl_t;

    // input transaction
    typedef struct packed {
        op_t                  operation;
        logic [VALUE_W-1:0]   push_value;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [VALUE_W-1:0]   pop_value;
        logic                 was_empty;
        logic                 overflow;
        logic [OCC_W-1:0]     occupancy;
    } out_item_t;

endpackage

[hw/rtl/ddq_chan_if.sv]
// valid/ready channel carrying one payload per transaction
`timescale 1ns / 1ps

interface ddq_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[hw/rtl/ddq_cell.sv]
// one storage cell: front-ordered byte and rear-ordered byte
`timescale 1ns / 1ps

module ddq_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  ddq_pkg::cell_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]             count,
    input  logic [ddq_pkg::VALUE_W-1:0]  front_left,
    input  logic [ddq_pkg::VALUE_W-1:0]  front_right,
    input  logic [ddq_pkg::VALUE_W-1:0]  rear_left,
    input  logic [ddq_pkg::VALUE_W-1:0]  rear_right,
    output logic [ddq_pkg::VALUE_W-1:0]  front_val,
    output logic [ddq_pkg::VALUE_W-1:0]  rear_val
);

    logic [ddq_pkg::VALUE_W-1:0] front_reg;
    logic [ddq_pkg::VALUE_W-1:0] front_next;
    logic [ddq_pkg::VALUE_W-1:0] rear_reg;
    logic [ddq_pkg::VALUE_W-1:0] rear_next;
    logic                        hit;

    // next value of one row given its move
    function automatic logic [ddq_pkg::VALUE_W-1:0] cell_next(
        input ddq_pkg::cell_op_t             op,
        input logic [ddq_pkg::VALUE_W-1:0]   own,
        input logic [ddq_pkg::VALUE_W-1:0]   left,
        input logic [ddq_pkg::VALUE_W-1:0]   right,
        input logic [ddq_pkg::VALUE_W-1:0]   value,
        input logic                          sel
    );
        logic [ddq_pkg::VALUE_W-1:0] res;
        case (op)
            ddq_pkg::CELL_SHIFT_IN:  res = left;
            ddq_pkg::CELL_SHIFT_OUT: res = right;
            ddq_pkg::CELL_LOAD:      res = sel ? value : own;
            default:                 res = own;
        endcase
        return res;
    endfunction

    // this cell is the first free slot
    assign hit = (count == CNT_W'(INDEX));

    always_comb
    begin
        front_next = cell_next(ctrl.front_op, front_reg, front_left, front_right,
                               ctrl.value, hit);
        rear_next  = cell_next(ctrl.rear_op, rear_reg, rear_left, rear_right,
                               ctrl.value, hit);
    end

    // data registers, no reset
    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
    end

    assign front_val = front_reg;
    assign rear_val  = rear_reg;

endmodule

[hw/rtl/double_ended_queue.sv]
// Bounded double-ended byte queue built as a row of DEPTH shifting cells.
// One transaction is accepted every clock cycle; its result appears in the
// output register on the following cycle and a new transaction is taken
// while that result waits, as long as the result is taken in the same cycle.
// Each cell holds the entry at its position counted from the front and the
// entry at its position counted from the rear, so both ends are always at
// cell 0 and every push or pop is a shift or write across the
// row. The count register bounds every read, so a stored byte is never read
// before it was written. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ddq_chan_if.sink    req,
    ddq_chan_if.source  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    ddq_pkg::out_item_t          out_data_reg;
    ddq_pkg::out_item_t          out_data_next;
    ddq_pkg::cell_ctrl_t         ctrl;
    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        is_push;
    logic                        is_pop;
    logic                        full_push;
    logic                        empty_pop;
    logic                        empty_result;
    logic [ddq_pkg::OCC_W-1:0]   occ_now;
    logic [ddq_pkg::VALUE_W-1:0] front_val [DEPTH];
    logic [ddq_pkg::VALUE_W-1:0] rear_val  [DEPTH];

    // handshake
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    // operation decode and result
    always_comb
    begin
        ctrl.front_op  = ddq_pkg::CELL_HOLD;
        ctrl.rear_op   = ddq_pkg::CELL_HOLD;
        ctrl.value     = req.data.push_value;
        count_next     = count_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (accept)
        begin
            out_valid_next          = 1'b1;
            out_data_next.pop_value = '0;
            out_data_next.was_empty = 1'b0;
            out_data_next.overflow  = 1'b0;
            case (req.data.operation)
                ddq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        out_data_next.overflow = 1'b1;
                    end
                    else
                    begin
                        ctrl.front_op = ddq_pkg::CELL_SHIFT_IN;
                        ctrl.rear_op  = ddq_pkg::CELL_LOAD;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                ddq_pkg::OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        out_data_next.overflow = 1'b1;
                    end
                    else
                    begin
                        ctrl.front_op = ddq_pkg::CELL_LOAD;
                        ctrl.rear_op  = ddq_pkg::CELL_SHIFT_IN;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                ddq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        out_data_next.was_empty = 1'b1;
                    end
                    else
                    begin
                        ctrl.front_op           = ddq_pkg::CELL_SHIFT_OUT;
                        out_data_next.pop_value = front_val[0];
                        count_next              = count_reg - CNT_W'(1);
                    end
                end
                ddq_pkg::OP_POP_REAR:
                begin
                    if (empty)
                    begin
                        out_data_next.was_empty = 1'b1;
                    end
                    else
                    begin
                        ctrl.rear_op            = ddq_pkg::CELL_SHIFT_OUT;
                        out_data_next.pop_value = rear_val[0];
                        count_next              = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            out_data_next.occupancy = ddq_pkg::OCC_W'(count_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // row of cells, a pushed byte shifts in at cell 0 of one row and loads at the first free cell of the other
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ddq_pkg::VALUE_W-1:0] front_left;
        logic [ddq_pkg::VALUE_W-1:0] front_right;
        logic [ddq_pkg::VALUE_W-1:0] rear_left;
        logic [ddq_pkg::VALUE_W-1:0] rear_right;

        if (i == 0)
        begin : g_head
            assign front_left = req.data.push_value;
            assign rear_left  = req.data.push_value;
        end
        else
        begin : g_body
            assign front_left = front_val[i-1];
            assign rear_left  = rear_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign front_right = '0;
            assign rear_right  = '0;
        end
        else
        begin : g_inner
            assign front_right = front_val[i+1];
            assign rear_right  = rear_val[i+1];
        end

        ddq_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .front_left  (front_left),
            .front_right (front_right),
            .rear_left   (rear_left),
            .rear_right  (rear_right),
            .front_val   (front_val[i]),
            .rear_val    (rear_val[i])
        );
    end

    // terms used by the checks
    assign is_push      = (req.data.operation == ddq_pkg::OP_PUSH_FRONT) ||
                          (req.data.operation == ddq_pkg::OP_PUSH_REAR);
    assign is_pop       = (req.data.operation == ddq_pkg::OP_POP_FRONT) ||
                          (req.data.operation == ddq_pkg::OP_POP_REAR);
    assign full_push    = accept && full && is_push;
    assign empty_pop    = accept && empty && is_pop;
    assign empty_result = rsp.valid && rsp.data.was_empty && (rsp.data.pop_value == '0);
    assign occ_now      = ddq_pkg::OCC_W'(count_reg);

    // checks
    `DEQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `DEQ_ASSERT_NEXT(a_full_push_holds, clk, rst_n, full_push, $stable(count_reg) && rsp.data.overflow)
    `DEQ_ASSERT_NEXT(a_empty_pop_zero, clk, rst_n, empty_pop, empty_result)
    `DEQ_ASSERT_NOW(a_occ_matches, clk, rst_n, rsp.valid, rsp.data.occupancy == occ_now)

endmodule

[tb/tb_double_ended_queue.sv]
// self-checking testbench for the double-ended byte queue
`timescale 1ns / 1ps

module tb_double_ended_queue;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
    localparam int BURST_ITEMS  = 24;
    localparam int LONG_STALL   = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    // shadow deque that predicts every result and holds them until they come back
    class deque_scoreboard;
        logic [ddq_pkg::VALUE_W-1:0] slots [DEPTH];
        int unsigned                 head;
        int unsigned                 tail;
        int unsigned                 held;
        ddq_pkg::out_item_t          awaited_results [$];
        int unsigned                 mismatches;

        function new();
            head       = 0;
            tail       = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        // accepted request: update the shadow deque and queue its result
        function void note_request(ddq_pkg::in_item_t item);
            ddq_pkg::out_item_t outcome;
            outcome = '0;
            case (item.operation)
                ddq_pkg::OP_PUSH_FRONT, ddq_pkg::OP_PUSH_REAR:
                begin
                    if (held >= DEPTH)
                        outcome.overflow = 1'b1;
                    else if (item.operation == ddq_pkg::OP_PUSH_FRONT)
                    begin
                        head        = (head == 0) ? DEPTH - 1 : head - 1;
                        slots[head] = item.push_value;
                        held++;
                    end
                    else
                    begin
                        slots[tail] = item.push_value;
                        tail        = (tail == DEPTH - 1) ? 0 : tail + 1;
                        held++;
                    end
                end
                default:
                begin
                    if (held == 0)
                        outcome.was_empty = 1'b1;
                    else if (item.operation == ddq_pkg::OP_POP_FRONT)
                    begin
                        outcome.pop_value = slots[head];
                        head              = (head == DEPTH - 1) ? 0 : head + 1;
                        held--;
                    end
                    else
                    begin
                        tail              = (tail == 0) ? DEPTH - 1 : tail - 1;
                        outcome.pop_value = slots[tail];
                        held--;
                    end
                end
            endcase
            outcome.occupancy = held[ddq_pkg::OCC_W-1:0];
            awaited_results.push_back(outcome);
        endfunction

        // accepted result: compare against the oldest prediction
        function void check_result(ddq_pkg::out_item_t got);
            ddq_pkg::out_item_t want;
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transaction: pop_value %0d occupancy %0d",
                       got.pop_value, got.occupancy);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.pop_value !== want.pop_value)
            begin
                $error("pop_value: expected %0d, actual %0d", want.pop_value, got.pop_value);
                mismatches++;
            end
            if (got.was_empty !== want.was_empty)
            begin
                $error("was_empty: expected %0d, actual %0d", want.was_empty, got.was_empty);
                mismatches++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                mismatches++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          long_stall_req = 1'b0;

    deque_scoreboard sb = new();

    ddq_chan_if #(.payload_t(ddq_pkg::in_item_t))  req_if ();
    ddq_chan_if #(.payload_t(ddq_pkg::out_item_t)) rsp_if ();

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.data);
        end
    end

    // result sink: random back-pressure plus one long hold-off on request
    initial
    begin
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    // offer one request and hold it until the queue takes it
    task automatic offer_request(ddq_pkg::op_t op, logic [ddq_pkg::VALUE_W-1:0] value);
        ddq_pkg::in_item_t item;
        item.operation  = op;
        item.push_value = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // random run of operations leaning toward pushes or pops
    task automatic random_burst(int unsigned push_pct);
        ddq_pkg::op_t op;
        for (int i = 0; i < BURST_ITEMS; i++)
        begin
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? ddq_pkg::OP_PUSH_REAR : ddq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(1) ? ddq_pkg::OP_POP_REAR : ddq_pkg::OP_POP_FRONT;
            offer_request(op, ddq_pkg::VALUE_W'($urandom_range(255)));
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int unsigned lean;
        rst_n         <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.data   <= '0;
        send_idle_pct = 22;
        recv_idle_pct = 69;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pops, value extremes, front wrap below slot zero, pops from both ends
        offer_request(ddq_pkg::OP_POP_FRONT,  8'h00);
        offer_request(ddq_pkg::OP_POP_REAR,   8'hFF);
        offer_request(ddq_pkg::OP_PUSH_FRONT, 8'h00);
        offer_request(ddq_pkg::OP_PUSH_REAR,  8'hFF);
        offer_request(ddq_pkg::OP_PUSH_FRONT, 8'hAA);
        offer_request(ddq_pkg::OP_PUSH_REAR,  8'h55);
        offer_request(ddq_pkg::OP_POP_REAR,   8'h00);
        offer_request(ddq_pkg::OP_POP_FRONT,  8'hFF);
        offer_request(ddq_pkg::OP_POP_FRONT,  8'h00);
        offer_request(ddq_pkg::OP_POP_REAR,   8'h00);
        offer_request(ddq_pkg::OP_POP_REAR,   8'h00);
        offer_request(ddq_pkg::OP_PUSH_REAR,  8'h80);
        offer_request(ddq_pkg::OP_PUSH_FRONT, 8'h01);
        offer_request(ddq_pkg::OP_POP_FRONT,  8'h00);
        offer_request(ddq_pkg::OP_POP_FRONT,  8'h00);

        // three idling profiles; the last one also carries the long hold-off
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_idle_pct  = 0;
                    long_stall_req = 1'b1;
                end
            endcase
            for (int b = 0; b < PHASE_ITEMS / BURST_ITEMS; b++)
            begin
                // fill toward full, drain toward empty, or stay balanced
                case ($urandom_range(2))
                    0:       lean = 90;
                    1:       lean = 10;
                    default: lean = 50;
                endcase
                random_burst(lean);
            end
        end
        req_if.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ddq_pkg.sv
hw/rtl/ddq_chan_if.sv
hw/rtl/ddq_cell.sv
hw/rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
